>>> design/dhc_pkg.sv
// ----------------------------------------------------------------------------
// dhc_pkg: shared types and constants for the hash-digest HSL to RGB converter
// Holds the fixed-point constants, the hue sector code and the bundle that
// passes hue and tone terms from the front stages to the mixing stages.
// ----------------------------------------------------------------------------
package dhc_pkg;

  // Number of register stages from input transfer to output register.
  localparam int unsigned NumStages = 9;

  // Reciprocal of 360 scaled by 2^24, rounded up; exact for 16-bit seeds.
  localparam logic [15:0] RecipDeg    = 16'd46604;
  localparam logic [8:0]  DegFull     = 9'd360;
  // One 60-degree sector in hue units of 1/360 degree.
  localparam logic [17:0] SectorUnits = 18'd21600;
  localparam logic [17:0] PairUnits   = 18'd43200;

  // Channel values are held in units of 1/16200000 (half the base unit).
  localparam logic [23:0] ChromaScale = 24'd21600;
  localparam logic [23:0] HalfChroma  = 24'd10800;
  localparam logic [23:0] LightScale  = 24'd540000;
  localparam logic [33:0] RoundBias   = 34'd8100000;
  // Rounding divisor is 64 * 253125; the power of two is a shift.
  localparam logic [26:0] DivOdd      = 27'd253125;
  localparam logic [14:0] DivRecip    = 15'd16967;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,  // red to yellow: (c, x, 0)
    SEC_YG = 3'd1,  // yellow to green: (x, c, 0)
    SEC_GC = 3'd2,  // green to cyan: (0, c, x)
    SEC_CB = 3'd3,  // cyan to blue: (0, x, c)
    SEC_BM = 3'd4,  // blue to magenta: (x, 0, c)
    SEC_MR = 3'd5   // magenta to red and beyond: (c, 0, x)
  } sector_e;

  typedef logic [24:0] chan_w_t;

  typedef struct packed {
    sector_e     sector;
    logic [14:0] tri_w;   // triangle wave of hue, 0..21600
    logic [9:0]  chroma;  // chroma numerator, c = chroma / 750
    logic [3:0]  lit;     // lightness nibble
  } hue_tone_t;

endpackage

>>> design/dhc_front.sv
// ----------------------------------------------------------------------------
// dhc_front: hue and tone front stages
// Reduces the 16-bit seed to a scaled hue, finds the saturated sector and
// the triangle term, and forms the chroma numerator from the tone byte.
// ----------------------------------------------------------------------------
module dhc_front import dhc_pkg::*; (
  input  logic                 clk_i,
  input  logic [NumStages-1:0] en_i,
  input  logic [7:0]           hue_high_byte_i,
  input  logic [7:0]           hue_low_byte_i,
  input  logic [7:0]           tone_byte_i,
  output hue_tone_t            terms_o
);

  logic [15:0] seed_in;
  logic [31:0] quo_prod;
  logic [4:0]  lit2, dev, span;
  logic [9:0]  chroma_d;

  logic [15:0] seed0_q, seed1_q;
  logic [7:0]  quo_q;
  logic [8:0]  rmd_q;
  logic [17:0] hue_q;
  logic [9:0]  cn0_q, cn1_q, cn2_q;
  logic [3:0]  lit0_q, lit1_q, lit2_q;
  hue_tone_t   terms_q;

  logic [16:0] quo_deg;
  logic [17:0] rem_pre;
  logic [15:0] rem_w;
  sector_e     sector_d;
  logic [14:0] tri_d;

  assign seed_in  = {hue_high_byte_i, hue_low_byte_i};
  assign quo_prod = 32'(seed_in) * 32'(RecipDeg);

  // Chroma numerator: (30 - |2l - 6|) * (10 + s).
  assign lit2     = {tone_byte_i[3:0], 1'b0};
  assign dev      = (lit2 > 5'd6) ? (lit2 - 5'd6) : (5'd6 - lit2);
  assign span     = 5'd30 - dev;
  assign chroma_d = 10'(span) * 10'(5'd10 + 5'(tone_byte_i[7:4]));

  assign quo_deg  = 17'(quo_q) * 17'(DegFull);

  always_comb begin
    if (hue_q >= 18'(4 * PairUnits)) begin
      rem_pre = hue_q - 18'(4 * PairUnits);
    end else if (hue_q >= 18'(3 * PairUnits)) begin
      rem_pre = hue_q - 18'(3 * PairUnits);
    end else if (hue_q >= 18'(2 * PairUnits)) begin
      rem_pre = hue_q - 18'(2 * PairUnits);
    end else if (hue_q >= PairUnits) begin
      rem_pre = hue_q - PairUnits;
    end else begin
      rem_pre = hue_q;
    end
    rem_w = rem_pre[15:0];
    if (18'(rem_w) >= SectorUnits) begin
      tri_d = 15'(PairUnits - 18'(rem_w));
    end else begin
      tri_d = rem_w[14:0];
    end
    // Hues beyond 360 degrees stay in the last sector.
    if (hue_q >= 18'(5 * SectorUnits)) begin
      sector_d = SEC_MR;
    end else if (hue_q >= 18'(4 * SectorUnits)) begin
      sector_d = SEC_BM;
    end else if (hue_q >= 18'(3 * SectorUnits)) begin
      sector_d = SEC_CB;
    end else if (hue_q >= 18'(2 * SectorUnits)) begin
      sector_d = SEC_GC;
    end else if (hue_q >= SectorUnits) begin
      sector_d = SEC_YG;
    end else begin
      sector_d = SEC_RY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      seed0_q <= seed_in;
      quo_q   <= quo_prod[31:24];
      cn0_q   <= chroma_d;
      lit0_q  <= tone_byte_i[3:0];
    end
    if (en_i[1]) begin
      seed1_q <= seed0_q;
      rmd_q   <= 9'(seed0_q - quo_deg[15:0]);
      cn1_q   <= cn0_q;
      lit1_q  <= lit0_q;
    end
    if (en_i[2]) begin
      hue_q  <= 18'(rmd_q) * 18'(DegFull) + 18'(seed1_q);
      cn2_q  <= cn1_q;
      lit2_q <= lit1_q;
    end
    if (en_i[3]) begin
      terms_q.sector <= sector_d;
      terms_q.tri_w  <= tri_d;
      terms_q.chroma <= cn2_q;
      terms_q.lit    <= lit2_q;
    end
  end

  assign terms_o = terms_q;

endmodule

>>> design/dhc_mix.sv
// ----------------------------------------------------------------------------
// dhc_mix: chroma, secondary and offset terms, then sector routing
// Forms c, x and m in a common unit and adds m to the routed c or x.
// ----------------------------------------------------------------------------
module dhc_mix import dhc_pkg::*; (
  input  logic                 clk_i,
  input  logic [NumStages-1:0] en_i,
  input  hue_tone_t            terms_i,
  output chan_w_t              chan_o [3]
);

  logic [23:0] cw_q, xw_q, mw_q;
  sector_e     sector_q;
  logic [23:0] light_w, half_w;
  chan_w_t     r_d, g_d, b_d;
  chan_w_t     chan_q [3];

  assign light_w = 24'(5'd12 + 5'(terms_i.lit)) * LightScale;
  assign half_w  = 24'(terms_i.chroma) * HalfChroma;

  always_comb begin
    case (sector_q)
      SEC_RY: begin
        r_d = 25'(cw_q); g_d = 25'(xw_q); b_d = '0;
      end
      SEC_YG: begin
        r_d = 25'(xw_q); g_d = 25'(cw_q); b_d = '0;
      end
      SEC_GC: begin
        r_d = '0; g_d = 25'(cw_q); b_d = 25'(xw_q);
      end
      SEC_CB: begin
        r_d = '0; g_d = 25'(xw_q); b_d = 25'(cw_q);
      end
      SEC_BM: begin
        r_d = 25'(xw_q); g_d = '0; b_d = 25'(cw_q);
      end
      default: begin
        r_d = 25'(cw_q); g_d = '0; b_d = 25'(xw_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      cw_q     <= 24'(terms_i.chroma) * ChromaScale;
      xw_q     <= 24'(terms_i.chroma) * 24'(terms_i.tri_w);
      mw_q     <= light_w - half_w;
      sector_q <= terms_i.sector;
    end
    if (en_i[5]) begin
      chan_q[0] <= r_d + 25'(mw_q);
      chan_q[1] <= g_d + 25'(mw_q);
      chan_q[2] <= b_d + 25'(mw_q);
    end
  end

  assign chan_o = chan_q;

endmodule

>>> design/dhc_round.sv
// ----------------------------------------------------------------------------
// dhc_round: one channel lane of scale-to-8-bit with half-up rounding
// Computes floor((255 * w + 8100000) / 16200000) by a shift, a reciprocal
// multiply and a single correction step, then clamps to 255.
// ----------------------------------------------------------------------------
module dhc_round import dhc_pkg::*; (
  input  logic                 clk_i,
  input  logic [NumStages-1:0] en_i,
  input  chan_w_t              chan_i,
  output logic [7:0]           level_o
);

  logic [33:0] num;
  logic [41:0] recip_prod;
  logic [26:0] back_mul;
  logic [18:0] rem;
  logic [8:0]  quo_fix;

  logic [25:0] nsh_q, nsh1_q;
  logic [8:0]  quo_q;
  logic [7:0]  level_q;

  assign num        = 34'(chan_i) * 34'd255 + RoundBias;
  assign recip_prod = 42'(nsh_q) * 42'(DivRecip);
  // The estimate is low by at most one, so one compare finishes it.
  assign back_mul   = 27'(quo_q) * DivOdd;
  assign rem        = 19'(27'(nsh1_q) - back_mul);
  assign quo_fix    = (27'(rem) >= DivOdd) ? (quo_q + 9'd1) : quo_q;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      nsh_q <= 26'(num >> 6);
    end
    if (en_i[7]) begin
      quo_q  <= 9'(recip_prod >> 32);
      nsh1_q <= nsh_q;
    end
    if (en_i[8]) begin
      level_q <= (quo_fix > 9'd255) ? 8'd255 : quo_fix[7:0];
    end
  end

  assign level_o = level_q;

endmodule

>>> design/digest_hsl_color_to_rgb.sv
// ----------------------------------------------------------------------------
// digest_hsl_color_to_rgb: three hash bytes to one 8-bit RGB colour
// Hue, saturation and lightness are taken from the bytes and converted to
// RGB in exact fixed point, with each channel rounded half up.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+------------------------------------
//   input   | in_valid_i / in_ready_o    | hue_high_byte_i, hue_low_byte_i,
//           |                            | tone_byte_i
//   output  | out_valid_o / out_ready_i  | red_o, green_o, blue_o
//
// The datapath is a nine-stage pipeline and takes one item in every cycle
// while the output side is not stalled. The depth is set by the chain of
// constant divisions: the seed reduction modulo 360 and the final scaling
// of each channel. Each stage holds a valid bit; a stage loads whenever it
// is empty or the stage after it moves, so bubbles close up and a stalled
// output still lets the earlier stages fill. Reset clears only the valid
// bits.
//
module digest_hsl_color_to_rgb import dhc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] hue_high_byte_i,
  input  logic [7:0] hue_low_byte_i,
  input  logic [7:0] tone_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  // Stage valid bits and per-stage load enables.
  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] en;

  hue_tone_t terms;
  chan_w_t   chan [3];
  logic [7:0] level [3];

  // A stage may load when it is empty or its content moves on. The last
  // stage is the output register, which moves on an output transfer.
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stages 0 to 3: seed reduction, hue sector, triangle term and chroma.
  dhc_front u_front (
    .clk_i           (clk_i),
    .en_i            (en),
    .hue_high_byte_i (hue_high_byte_i),
    .hue_low_byte_i  (hue_low_byte_i),
    .tone_byte_i     (tone_byte_i),
    .terms_o         (terms)
  );

  // Stages 4 and 5: c, x and m terms, routed to the three channels.
  dhc_mix u_mix (
    .clk_i   (clk_i),
    .en_i    (en),
    .terms_i (terms),
    .chan_o  (chan)
  );

  // Stages 6 to 8: one rounding lane for each channel.
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    dhc_round u_round (
      .clk_i   (clk_i),
      .en_i    (en),
      .chan_i  (chan[ch]),
      .level_o (level[ch])
    );
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign red_o       = level[0];
  assign green_o     = level[1];
  assign blue_o      = level[2];

endmodule

>>> design/dhc_checker.sv
// ----------------------------------------------------------------------------
// dhc_checker: port-level checks for the HSL to RGB converter
// Watches the ports of the top level and flags stall, drain and readiness
// faults; attached to every instance of the top level by a bind.
// ----------------------------------------------------------------------------
module dhc_checker import dhc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] hue_high_byte_i,
  input logic [7:0] hue_low_byte_i,
  input logic [7:0] tone_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o
);

  // Cycles in a row with no input transfer and the output side ready.
  logic [3:0] idle_q;
  logic       in_xfer;

  assign in_xfer = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= '0;
    end else if (in_xfer || !out_ready_i) begin
      idle_q <= '0;
    end else if (idle_q != 4'hF) begin
      idle_q <= idle_q + 4'd1;
    end
  end

  // A waiting input item stays offered with the same bytes.
  a_in_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(hue_high_byte_i) && $stable(hue_low_byte_i) &&
      $stable(tone_byte_i))
    else $error("input item changed before transfer");

  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output result withdrawn before transfer");

  // A stalled result keeps its colour.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("output colour changed while stalled");

  // Whenever the output register can move, the pipeline takes new input.
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled although the pipeline can advance");

  // With no new input and a ready consumer, the pipeline drains.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle_q >= 4'(NumStages + 1)) |-> !out_valid_o)
    else $error("result appeared with no input in flight");

endmodule

bind digest_hsl_color_to_rgb dhc_checker u_dhc_checker (.*);
